// ===== hw/rtl/ihds_pkg.sv =====
// ---------------------------------------------------------------------------
// Image header sniffer package
// Shared types, codes and helper functions for the header sniffer.
// ---------------------------------------------------------------------------
package ihds_pkg;

  // Default number of leading file bytes that are examined.
  localparam int PREFIX_BYTES_DEF = 65536;

  // Bound on a JPEG segment jump beyond the prefix: two marker bytes plus a length.
  localparam int SEG_JUMP_MAX = 65538;

  // Result field widths and the packed output word.
  localparam int STATUS_W    = 3;
  localparam int DIM_W       = 32;
  localparam int COMP_W      = 8;
  localparam int OUT_FIELD_W = STATUS_W + 2 * DIM_W + 2 * COMP_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Header rule selected by the configuration register.
  typedef enum logic [1:0] {
    FMT_PNG  = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_BMP  = 2'd2,
    FMT_TGA  = 2'd3
  } fmt_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIG  = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_ZERO_DIM = 3'd3,
    ST_BAD_LEN  = 3'd4
  } status_t;

  // Marker and signature bytes.
  localparam logic [7:0] JPEG_FF   = 8'hFF;
  localparam logic [7:0] JPEG_SOI  = 8'hD8;
  localparam logic [7:0] JPEG_SOF0 = 8'hC0;
  localparam logic [7:0] JPEG_SOF1 = 8'hC1;
  localparam logic [7:0] JPEG_SOF2 = 8'hC2;
  localparam logic [7:0] BMP_SIG0  = 8'h42;
  localparam logic [7:0] BMP_SIG1  = 8'h4D;

  // One result item.
  typedef struct packed {
    status_t           header_status;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [COMP_W-1:0] component_bits;
    logic [COMP_W-1:0] component_count;
  } result_t;

  // Expected PNG signature byte at a given position.
  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd137;
      3'd1:    v = 8'd80;
      3'd2:    v = 8'd78;
      3'd3:    v = 8'd71;
      3'd4:    v = 8'd13;
      3'd5:    v = 8'd10;
      3'd6:    v = 8'd26;
      default: v = 8'd10;
    endcase
    return v;
  endfunction

  // Component count from the PNG colour type.
  function automatic logic [7:0] png_count(input logic [7:0] colour);
    logic [7:0] v;
    case (colour) inside
      8'd0, 8'd3: v = 8'd1;
      8'd2:       v = 8'd3;
      8'd4:       v = 8'd2;
      default:    v = 8'd4;
    endcase
    return v;
  endfunction

  // Bits per component from a BMP or TGA pixel depth.
  function automatic logic [7:0] depth_bits(input logic [15:0] d);
    return (d >= 16'd24) ? 8'd8 : d[7:0];
  endfunction

  // Component count from a BMP or TGA pixel depth.
  function automatic logic [7:0] depth_count(input logic [15:0] d);
    logic [7:0] v;
    if (d >= 16'd32) begin
      v = 8'd4;
    end else if (d >= 16'd24) begin
      v = 8'd3;
    end else begin
      v = 8'd1;
    end
    return v;
  endfunction

  // Build a result: zero dimensions turn into an error, and errors clear fields.
  function automatic result_t make_result(input status_t st, input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h,
                                          input logic [COMP_W-1:0] bits,
                                          input logic [COMP_W-1:0] count);
    result_t r;
    status_t s;
    s = st;
    if (s == ST_OK && (w == '0 || h == '0)) begin
      s = ST_ZERO_DIM;
    end
    r.header_status = s;
    if (s == ST_OK) begin
      r.image_width     = w;
      r.image_height    = h;
      r.component_bits  = bits;
      r.component_count = count;
    end else begin
      r.image_width     = '0;
      r.image_height    = '0;
      r.component_bits  = '0;
      r.component_count = '0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ihds_parse.sv =====
// ---------------------------------------------------------------------------
// Image header field parser
// Holds the per-image header state and decodes one byte per step.
// ---------------------------------------------------------------------------
module ihds_parse #(
  parameter int PREFIX_BYTES = ihds_pkg::PREFIX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_image,
  input  ihds_pkg::fmt_t   image_format,
  output logic             emit,
  output ihds_pkg::result_t result
);
  import ihds_pkg::*;

  localparam int POS_W = $clog2(PREFIX_BYTES + 1);
  localparam int SEG_W = $clog2(PREFIX_BYTES + SEG_JUMP_MAX + 1);

  // Per-image state.
  logic [POS_W-1:0] pos, pos_next;
  logic             decided, decided_next;
  logic [DIM_W-1:0] width_acc, width_acc_next;
  logic [DIM_W-1:0] height_acc, height_acc_next;
  logic [15:0]      depth_acc, depth_acc_next;
  logic [SEG_W-1:0] seg_start, seg_start_next;
  logic [15:0]      seg_len, seg_len_next;
  logic             sof, sof_next;

  // Decode helpers.
  logic             in_prefix;
  logic             step_emit;
  status_t          st;
  logic [DIM_W-1:0] rw, rh;
  logic [7:0]       rbits, rcount;
  logic [SEG_W-1:0] pos_ext, seg_d;
  logic [15:0]      len_full, bmp_depth;
  logic [1:0]       lane;

  assign in_prefix = (pos < POS_W'(PREFIX_BYTES));
  assign pos_ext   = SEG_W'(pos);
  assign seg_d     = pos_ext - seg_start;
  assign len_full  = {seg_len[15:8], seg_len[7:0] | data_byte};
  assign bmp_depth = depth_acc | {data_byte, 8'h00};
  assign lane      = pos[1:0] - 2'd2;

  // Per-format byte decode and next state.
  always_comb begin
    pos_next        = pos;
    decided_next    = decided;
    width_acc_next  = width_acc;
    height_acc_next = height_acc;
    depth_acc_next  = depth_acc;
    seg_start_next  = seg_start;
    seg_len_next    = seg_len;
    sof_next        = sof;
    step_emit       = 1'b0;
    st              = ST_OK;
    rw              = '0;
    rh              = '0;
    rbits           = '0;
    rcount          = '0;

    if (!decided && in_prefix) begin
      unique case (image_format)
        FMT_PNG: begin
          if (pos < POS_W'(8)) begin
            if (data_byte != png_sig(pos[2:0])) begin
              step_emit = 1'b1;
              st        = ST_BAD_SIG;
            end
          end else if (pos >= POS_W'(16) && pos <= POS_W'(19)) begin
            width_acc_next = {width_acc[DIM_W-9:0], data_byte};
          end else if (pos >= POS_W'(20) && pos <= POS_W'(23)) begin
            height_acc_next = {height_acc[DIM_W-9:0], data_byte};
          end else if (pos == POS_W'(24)) begin
            depth_acc_next = {8'h00, data_byte};
          end else if (pos == POS_W'(25)) begin
            depth_acc_next = {data_byte, depth_acc[7:0]};
          end else if (pos == POS_W'(28)) begin
            step_emit = 1'b1;
            rw        = width_acc;
            rh        = height_acc;
            rbits     = depth_acc[7:0];
            rcount    = png_count(depth_acc[15:8]);
          end
        end
        FMT_BMP: begin
          if (pos == POS_W'(0) && data_byte != BMP_SIG0) begin
            step_emit = 1'b1;
            st        = ST_BAD_SIG;
          end else if (pos == POS_W'(1) && data_byte != BMP_SIG1) begin
            step_emit = 1'b1;
            st        = ST_BAD_SIG;
          end else if (pos >= POS_W'(18) && pos <= POS_W'(21)) begin
            // Little-endian: byte 18 lands in the low lane.
            width_acc_next[8*lane +: 8] = width_acc[8*lane +: 8] | data_byte;
          end else if (pos >= POS_W'(22) && pos <= POS_W'(25)) begin
            height_acc_next[8*lane +: 8] = height_acc[8*lane +: 8] | data_byte;
          end else if (pos == POS_W'(28)) begin
            depth_acc_next = {8'h00, data_byte};
          end else if (pos == POS_W'(29)) begin
            step_emit = 1'b1;
            rw        = width_acc;
            rh        = height_acc;
            rbits     = depth_bits(bmp_depth);
            rcount    = depth_count(bmp_depth);
          end
        end
        FMT_TGA: begin
          if (pos == POS_W'(12)) begin
            width_acc_next[7:0] = width_acc[7:0] | data_byte;
          end else if (pos == POS_W'(13)) begin
            width_acc_next[15:8] = width_acc[15:8] | data_byte;
          end else if (pos == POS_W'(14)) begin
            height_acc_next[7:0] = height_acc[7:0] | data_byte;
          end else if (pos == POS_W'(15)) begin
            height_acc_next[15:8] = height_acc[15:8] | data_byte;
          end else if (pos == POS_W'(16)) begin
            depth_acc_next = {8'h00, data_byte};
          end else if (pos == POS_W'(17)) begin
            step_emit = 1'b1;
            rw        = width_acc;
            rh        = height_acc;
            rbits     = depth_bits(depth_acc);
            rcount    = depth_count(depth_acc);
          end
        end
        FMT_JPEG: begin
          if (pos == POS_W'(0) && data_byte != JPEG_FF) begin
            step_emit = 1'b1;
            st        = ST_BAD_SIG;
          end else if (pos == POS_W'(1) && data_byte != JPEG_SOI) begin
            step_emit = 1'b1;
            st        = ST_BAD_SIG;
          end else if (pos >= POS_W'(2) && pos_ext >= seg_start) begin
            // Walk the marker segment relative to its start.
            case (seg_d)
              SEG_W'(0): begin
                if (data_byte != JPEG_FF) begin
                  seg_start_next = pos_ext + SEG_W'(1);
                end
              end
              SEG_W'(1): begin
                sof_next = (data_byte == JPEG_SOF0) || (data_byte == JPEG_SOF1) ||
                           (data_byte == JPEG_SOF2);
              end
              SEG_W'(2): begin
                if (!sof) begin
                  seg_len_next = {data_byte, 8'h00};
                end
              end
              SEG_W'(3): begin
                if (!sof) begin
                  seg_len_next = len_full;
                  if (len_full < 16'd2) begin
                    step_emit = 1'b1;
                    st        = ST_BAD_LEN;
                  end else begin
                    seg_start_next = seg_start + SEG_W'(len_full) + SEG_W'(2);
                    sof_next       = 1'b0;
                  end
                end
              end
              SEG_W'(4): depth_acc_next = {8'h00, data_byte};
              SEG_W'(5): height_acc_next = {16'h0000, data_byte, 8'h00};
              SEG_W'(6): height_acc_next = height_acc | {24'h000000, data_byte};
              SEG_W'(7): width_acc_next = {16'h0000, data_byte, 8'h00};
              SEG_W'(8): width_acc_next = width_acc | {24'h000000, data_byte};
              SEG_W'(9): begin
                step_emit = 1'b1;
                rw        = width_acc;
                rh        = height_acc;
                rbits     = depth_acc[7:0];
                rcount    = data_byte;
              end
              default: ;
            endcase
          end
        end
      endcase
    end

    if (step_emit) begin
      decided_next = 1'b1;
    end
    if (in_prefix) begin
      pos_next = pos + POS_W'(1);
    end

    // A last byte with nothing decided reports a short file.
    emit = step_emit;
    if (end_of_image && !decided && !step_emit) begin
      emit = 1'b1;
      st   = ST_TRUNC;
    end

    // The last byte returns the image state to its starting point.
    if (end_of_image) begin
      pos_next        = '0;
      decided_next    = 1'b0;
      width_acc_next  = '0;
      height_acc_next = '0;
      depth_acc_next  = '0;
      seg_start_next  = SEG_W'(2);
      seg_len_next    = '0;
      sof_next        = 1'b0;
    end

    result = make_result(st, rw, rh, rbits, rcount);
  end

  // State registers, advanced once per consumed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      decided    <= 1'b0;
      width_acc  <= '0;
      height_acc <= '0;
      depth_acc  <= '0;
      seg_start  <= SEG_W'(2);
      seg_len    <= '0;
      sof        <= 1'b0;
    end else if (step) begin
      pos        <= pos_next;
      decided    <= decided_next;
      width_acc  <= width_acc_next;
      height_acc <= height_acc_next;
      depth_acc  <= depth_acc_next;
      seg_start  <= seg_start_next;
      seg_len    <= seg_len_next;
      sof        <= sof_next;
    end
  end

endmodule

// ===== hw/rtl/image_header_dimension_sniffer.sv =====
// ---------------------------------------------------------------------------
// Image header dimension sniffer
// Reads width, height and component layout from the leading bytes of a
// PNG, JPEG, BMP or TGA file and returns one result beat per image.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  --------  ---------  ----------------------------------------------------
//  s_*       in         one file byte per beat, tlast on the last byte
//  m_*       out        one header result per image
//  cfg_*     in         header rule: 0 png, 1 jpeg, 2 bmp, 3 tga
//
// One byte is taken every clock cycle unless a held byte waits for the output
// register. A byte is captured in the input register and decoded against the
// header state while it is held there; any result is loaded into the output
// register when the byte moves on, and m_tvalid follows the output register.
// Reset clears the handshake and header state; the rule resets to png.
// A byte that yields a result waits in the input register while the output
// register is still full and m_tready is low; other bytes keep flowing.
//
module image_header_dimension_sniffer #(
  parameter int PREFIX_BYTES = ihds_pkg::PREFIX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input beats.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte[7:0]
  input  logic                             s_tlast,   // end_of_image
  // Result beats.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // header_status[2:0], image_width[34:3], image_height[66:35],
  // component_bits[74:67], component_count[82:75], zero fill above
  output logic [ihds_pkg::OUT_TDATA_W-1:0] m_tdata,
  // Configuration.
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_wdata
);
  import ihds_pkg::*;

  fmt_t       image_format;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  result_t    out_result;
  logic       emit;
  result_t    result;
  logic       advance;
  logic       s_fire;

  // Header rule register.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_format <= FMT_PNG;
    end else if (cfg_we) begin
      image_format <= fmt_t'(cfg_wdata);
    end
  end

  // A held byte moves on unless it needs the output register and that is full with m_tready low.
  assign advance  = in_valid && (!emit || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Header decode and state.
  ihds_parse #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (in_byte),
    .end_of_image(in_last),
    .image_format(image_format),
    .emit        (emit),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= result;
    end
  end

  // Pack the result fields, first field in the low bits.
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_result.component_count,
                                  out_result.component_bits,
                                  out_result.image_height,
                                  out_result.image_width,
                                  out_result.header_status});

endmodule

// ===== test/ihds_checker.sv =====
// ---------------------------------------------------------------------------
// Header sniffer checker
// Watches the byte, result and configuration ports of the header sniffer.
// For every accepted byte beat it updates its own copy of the header state
// and queues the result that the byte should produce. Each result beat is
// compared field by field with the oldest queued result.
// ---------------------------------------------------------------------------
module ihds_checker #(
  parameter int PREFIX_BYTES = ihds_pkg::PREFIX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ihds_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_wdata,
  output int                               mismatches,
  output int                               pending_results
);

  import ihds_pkg::*;

  // PNG signature, first byte in the lowest bits.
  localparam logic [63:0] PNG_MAGIC = 64'h0A1A0A0D_474E5089;

  // Header state of the image in flight.
  fmt_t        hdr_fmt;
  int unsigned byte_pos;
  int unsigned seg_base;
  bit          hdr_done;
  bit          sof_seen;
  logic [31:0] wid_acc;
  logic [31:0] hgt_acc;
  logic [15:0] dep_acc;
  logic [15:0] seg_len;

  // Results still owed by the block, oldest first.
  result_t header_results[$];
  result_t want_r;
  result_t new_r;

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  // Return the per-image state to its idle values.
  function automatic void clear_image();
    byte_pos = 0;
    seg_base = 2;
    hdr_done = 1'b0;
    sof_seen = 1'b0;
    wid_acc  = '0;
    hgt_acc  = '0;
    dep_acc  = '0;
    seg_len  = '0;
  endfunction

  // Add a result at the tail of the owed list.
  function automatic void owe_result(input result_t r);
    header_results.insert(header_results.size(), r);
  endfunction

  // Close the image header: a zero dimension is an error, errors clear fields.
  function automatic result_t settle(input status_t st, input logic [31:0] w,
                                     input logic [31:0] h, input logic [7:0] bits,
                                     input logic [7:0] cnt);
    result_t r;
    status_t s;
    s = st;
    if (s == ST_OK && (w == '0 || h == '0)) begin
      s = ST_ZERO_DIM;
    end
    r.header_status   = s;
    r.image_width     = (s == ST_OK) ? w : '0;
    r.image_height    = (s == ST_OK) ? h : '0;
    r.component_bits  = (s == ST_OK) ? bits : '0;
    r.component_count = (s == ST_OK) ? cnt : '0;
    hdr_done = 1'b1;
    return r;
  endfunction

  // Bits per component for a BMP or TGA pixel depth.
  function automatic logic [7:0] comp_bits_of(input logic [15:0] d);
    return (d >= 16'd24) ? 8'd8 : d[7:0];
  endfunction

  // Component count for a BMP or TGA pixel depth.
  function automatic logic [7:0] comp_count_of(input logic [15:0] d);
    return (d >= 16'd32) ? 8'd4 : (d >= 16'd24) ? 8'd3 : 8'd1;
  endfunction

  // Advance the header state by one byte; returns 1 when a result is due.
  function automatic bit predict_byte(input logic [7:0] b, input bit last_byte,
                                      output result_t r);
    bit          hit;
    int unsigned p;
    int unsigned d;
    logic [7:0]  cnt;
    logic [15:0] dw;
    hit = 1'b0;
    p   = byte_pos;
    if (!hdr_done && p < PREFIX_BYTES) begin
      case (hdr_fmt)
        FMT_PNG: begin
          if (p < 8) begin
            if (b != PNG_MAGIC[8*p +: 8]) begin
              r   = settle(ST_BAD_SIG, '0, '0, '0, '0);
              hit = 1'b1;
            end
          end else if (p >= 16 && p <= 19) begin
            wid_acc = {wid_acc[23:0], b};
          end else if (p >= 20 && p <= 23) begin
            hgt_acc = {hgt_acc[23:0], b};
          end else if (p == 24) begin
            dep_acc = 16'(b);
          end else if (p == 25) begin
            dep_acc = dep_acc | {b, 8'h00};
          end else if (p == 28) begin
            // The colour type sits in the upper byte of the depth field.
            case (dep_acc[15:8])
              8'd0, 8'd3: cnt = 8'd1;
              8'd2:       cnt = 8'd3;
              8'd4:       cnt = 8'd2;
              default:    cnt = 8'd4;
            endcase
            r   = settle(ST_OK, wid_acc, hgt_acc, dep_acc[7:0], cnt);
            hit = 1'b1;
          end
        end
        FMT_JPEG: begin
          if ((p == 0 && b != JPEG_FF) || (p == 1 && b != JPEG_SOI)) begin
            r   = settle(ST_BAD_SIG, '0, '0, '0, '0);
            hit = 1'b1;
          end else if (p >= 2 && p >= seg_base) begin
            // Offset from the start of the current marker segment.
            d = p - seg_base;
            case (d)
              0: begin
                if (b != JPEG_FF) begin
                  seg_base = p + 1;
                end
              end
              1: sof_seen = (b == JPEG_SOF0 || b == JPEG_SOF1 || b == JPEG_SOF2);
              2: begin
                if (!sof_seen) begin
                  seg_len = {b, 8'h00};
                end
              end
              3: begin
                if (!sof_seen) begin
                  seg_len = seg_len | 16'(b);
                  if (seg_len < 16'd2) begin
                    r   = settle(ST_BAD_LEN, '0, '0, '0, '0);
                    hit = 1'b1;
                  end else begin
                    seg_base = seg_base + 2 + seg_len;
                    sof_seen = 1'b0;
                  end
                end
              end
              4: dep_acc = 16'(b);
              5: hgt_acc = 32'(b) << 8;
              6: hgt_acc = hgt_acc | 32'(b);
              7: wid_acc = 32'(b) << 8;
              8: wid_acc = wid_acc | 32'(b);
              9: begin
                r   = settle(ST_OK, wid_acc, hgt_acc, dep_acc[7:0], b);
                hit = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        FMT_BMP: begin
          if ((p == 0 && b != BMP_SIG0) || (p == 1 && b != BMP_SIG1)) begin
            r   = settle(ST_BAD_SIG, '0, '0, '0, '0);
            hit = 1'b1;
          end else if (p >= 18 && p <= 21) begin
            wid_acc = wid_acc | (32'(b) << (8 * (p - 18)));
          end else if (p >= 22 && p <= 25) begin
            hgt_acc = hgt_acc | (32'(b) << (8 * (p - 22)));
          end else if (p == 28) begin
            dep_acc = 16'(b);
          end else if (p == 29) begin
            dw  = dep_acc | {b, 8'h00};
            r   = settle(ST_OK, wid_acc, hgt_acc, comp_bits_of(dw), comp_count_of(dw));
            hit = 1'b1;
          end
        end
        default: begin
          // TGA has no signature; little-endian fields at fixed offsets.
          if (p == 12 || p == 13) begin
            wid_acc = wid_acc | (32'(b) << (8 * (p - 12)));
          end else if (p == 14 || p == 15) begin
            hgt_acc = hgt_acc | (32'(b) << (8 * (p - 14)));
          end else if (p == 16) begin
            dep_acc = 16'(b);
          end else if (p == 17) begin
            r   = settle(ST_OK, wid_acc, hgt_acc, comp_bits_of(dep_acc),
                         comp_count_of(dep_acc));
            hit = 1'b1;
          end
        end
      endcase
    end
    // The position stops counting at the prefix limit.
    if (p < PREFIX_BYTES) begin
      byte_pos = p + 1;
    end
    if (last_byte) begin
      if (!hdr_done) begin
        r   = settle(ST_TRUNC, '0, '0, '0, '0);
        hit = 1'b1;
      end
      clear_image();
    end
    return hit;
  endfunction

  // Report one result field that differs from the expectation.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sample all three ports at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      hdr_fmt = FMT_PNG;
      clear_image();
      header_results.delete();
    end else begin
      if (cfg_we) begin
        hdr_fmt = fmt_t'(cfg_wdata);
      end
      // A result beat must match the oldest owed result.
      if (m_tvalid && m_tready) begin
        if (header_results.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          want_r = header_results.pop_front();
          check_field("header_status", 32'(want_r.header_status), 32'(m_tdata[2:0]));
          check_field("image_width", want_r.image_width, m_tdata[34:3]);
          check_field("image_height", want_r.image_height, m_tdata[66:35]);
          check_field("component_bits", 32'(want_r.component_bits), 32'(m_tdata[74:67]));
          check_field("component_count", 32'(want_r.component_count),
                      32'(m_tdata[82:75]));
        end
      end
      // A byte beat may close the header of the current image.
      if (s_tvalid && s_tready) begin
        if (predict_byte(s_tdata, s_tlast, new_r)) begin
          owe_result(new_r);
        end
      end
    end
    pending_results = header_results.size();
  end

endmodule

// ===== test/tb_image_header_dimension_sniffer.sv =====
// ---------------------------------------------------------------------------
// Header sniffer testbench
// Feeds image file prefixes for all four header rules: first a set of
// hand-built headers for the corner cases, then random well-formed, broken
// and noise images under three idling patterns. The checker predicts and
// compares every result; this module drives the ports and reports the
// verdict.
// ---------------------------------------------------------------------------
module tb_image_header_dimension_sniffer;

  import ihds_pkg::*;

  // A short prefix lets some images run past the limit.
  localparam int PREFIX_LEN    = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 60;
  localparam logic [63:0] PNG_MAGIC = 64'h0A1A0A0D_474E5089;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [1:0]             cfg_wdata = '0;

  int   mismatches;
  int   pending_results;
  int   src_idle_pct = 27;
  int   dst_idle_pct = 60;
  int   phase_bytes;
  fmt_t cur_fmt;

  // Bytes of the image being built.
  logic [7:0] img[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  image_header_dimension_sniffer #(
    .PREFIX_BYTES(PREFIX_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  ihds_checker #(
    .PREFIX_BYTES(PREFIX_LEN)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending_results(pending_results)
  );

  // Result side back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Drive one byte beat and wait until it is taken.
  task automatic push_byte(input logic [7:0] b, input bit last_byte);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last_byte;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Send the built image; the final byte carries tlast when close is set.
  task automatic send_image(input bit close);
    for (int i = 0; i < img.size(); i++) begin
      push_byte(img[i], close && (i == img.size() - 1));
    end
    phase_bytes += img.size();
    img.delete();
  endtask

  // Wait until every owed result is out and the pipeline has emptied.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_results != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Select the header rule while the block is idle.
  task automatic set_format(input fmt_t f);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Add one byte at the end of the image being built.
  task automatic append_byte(input logic [7:0] b);
    img.insert(img.size(), b);
  endtask

  task automatic add_noise(input int n);
    repeat (n) append_byte(8'($urandom));
  endtask

  task automatic trim_to(input int n);
    while (img.size() > n) begin
      void'(img.pop_back());
    end
  endtask

  // Dimension with zero, full-range and small values; bits gives the field size.
  function automatic logic [31:0] pick_dim(input int bits);
    logic [31:0] v;
    int          r;
    r = $urandom_range(99);
    if (r < 8) begin
      v = '0;
    end else if (r < 38) begin
      v = $urandom;
    end else begin
      v = $urandom_range(1, 4096);
    end
    if (bits == 16) begin
      v[31:16] = '0;
    end
    return v;
  endfunction

  // Pixel depth around the thresholds of the depth mapping.
  function automatic logic [15:0] pick_depth();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'd1;
      1:       v = 16'd8;
      2:       v = 16'd16;
      3:       v = 16'd23;
      4:       v = 16'd24;
      5:       v = 16'd31;
      6:       v = 16'd32;
      7:       v = 16'd33;
      8:       v = 16'($urandom);
      default: v = 16'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic put_png(input logic [31:0] w, input logic [31:0] h,
                         input logic [7:0] bits, input logic [7:0] colour);
    for (int i = 0; i < 8; i++) begin
      append_byte(PNG_MAGIC[8*i +: 8]);
    end
    add_noise(8);
    for (int i = 3; i >= 0; i--) begin
      append_byte(w[8*i +: 8]);
    end
    for (int i = 3; i >= 0; i--) begin
      append_byte(h[8*i +: 8]);
    end
    append_byte(bits);
    append_byte(colour);
    add_noise(3 + $urandom_range(0, 4));
  endtask

  task automatic put_bmp(input logic [31:0] w, input logic [31:0] h,
                         input logic [15:0] depth);
    append_byte(BMP_SIG0);
    append_byte(BMP_SIG1);
    add_noise(16);
    for (int i = 0; i < 4; i++) begin
      append_byte(w[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      append_byte(h[8*i +: 8]);
    end
    add_noise(2);
    append_byte(depth[7:0]);
    append_byte(depth[15:8]);
    add_noise($urandom_range(0, 4));
  endtask

  task automatic put_tga(input logic [15:0] w, input logic [15:0] h,
                         input logic [7:0] depth);
    add_noise(12);
    append_byte(w[7:0]);
    append_byte(w[15:8]);
    append_byte(h[7:0]);
    append_byte(h[15:8]);
    append_byte(depth);
    add_noise(1 + $urandom_range(0, 4));
  endtask

  // JPEG with nseg leading segments, then a start-of-frame segment. When wild
  // is set a segment length may be too short or jump far ahead.
  task automatic put_jpeg(input logic [15:0] w, input logic [15:0] h,
                          input logic [7:0] bits, input logic [7:0] cnt,
                          input int nseg, input bit wild);
    logic [7:0]  mk;
    logic [15:0] len;
    int          r;
    append_byte(JPEG_FF);
    append_byte(JPEG_SOI);
    for (int k = 0; k < nseg; k++) begin
      // Now and then a stray byte that the scan steps over.
      if ($urandom_range(0, 4) == 0) begin
        append_byte(8'($urandom_range(0, 254)));
      end
      mk = 8'($urandom);
      if (mk >= JPEG_SOF0 && mk <= JPEG_SOF2) begin
        mk = 8'hE1;
      end
      append_byte(JPEG_FF);
      append_byte(mk);
      r = $urandom_range(99);
      if (!wild || r < 80) begin
        len = 16'($urandom_range(2, 10));
      end else if (r < 88) begin
        len = 16'($urandom_range(11, 60));
      end else if (r < 94) begin
        len = 16'($urandom_range(0, 1));
      end else begin
        len = 16'($urandom_range(16'h8000, 16'hFFFF));
      end
      append_byte(len[15:8]);
      append_byte(len[7:0]);
      if (len < 16'd2 || len > 16'd60) begin
        add_noise($urandom_range(0, 20));
        return;
      end
      add_noise(len - 2);
    end
    append_byte(JPEG_FF);
    append_byte(8'(JPEG_SOF0 + $urandom_range(0, 2)));
    add_noise(2);
    append_byte(bits);
    append_byte(h[15:8]);
    append_byte(h[7:0]);
    append_byte(w[15:8]);
    append_byte(w[7:0]);
    append_byte(cnt);
    add_noise($urandom_range(0, 4));
  endtask

  // Mostly well-formed headers with random content; the rest broken or noise.
  task automatic random_image(input fmt_t f);
    logic [7:0] colour;
    int         r;
    int         pos;
    r = $urandom_range(0, 7);
    colour = (r < 5) ? 8'(r) : (r == 5) ? 8'd6 : 8'($urandom);
    case (f)
      FMT_PNG:  put_png(pick_dim(32), pick_dim(32), 8'($urandom), colour);
      FMT_JPEG: put_jpeg(16'(pick_dim(16)), 16'(pick_dim(16)), 8'($urandom),
                         8'($urandom), $urandom_range(0, 3), 1'b1);
      FMT_BMP:  put_bmp(pick_dim(32), pick_dim(32), pick_depth());
      default:  put_tga(16'(pick_dim(16)), 16'(pick_dim(16)), 8'(pick_depth()));
    endcase
    r = $urandom_range(99);
    if (r < 10 && f != FMT_TGA) begin
      // Break one signature byte, sometimes in a file that also ends early.
      pos = (f == FMT_PNG) ? $urandom_range(0, 7) : $urandom_range(0, 1);
      img[pos] = img[pos] ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1) == 1) begin
        trim_to(pos + 1 + $urandom_range(0, 2));
      end
    end else if (r < 22) begin
      trim_to($urandom_range(1, img.size() - 1));
    end else if (r < 32) begin
      img.delete();
      add_noise($urandom_range(1, 40));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // PNG is the rule after reset: widest fields, zero height, early ends.
    put_png(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_image(1'b1);
    put_png(32'd1, 32'd0, 8'd8, 8'd2);
    send_image(1'b1);
    img = '{8'd137, 8'd80, 8'd78, 8'd0};
    send_image(1'b1);
    img = '{8'd137};
    send_image(1'b1);
    put_png(32'd640, 32'd480, 8'd16, 8'd4);
    trim_to(20);
    send_image(1'b1);

    // JPEG: a clean walk, a too-short length, a bad marker, a file past the prefix.
    set_format(FMT_JPEG);
    put_jpeg(16'hFFFF, 16'd1, 8'd8, 8'd3, 2, 1'b0);
    send_image(1'b1);
    img = '{JPEG_FF, JPEG_SOI, JPEG_FF, 8'hE0, 8'h00, 8'h01, 8'hAA};
    send_image(1'b1);
    img = '{JPEG_FF, 8'h00};
    send_image(1'b1);
    img = '{JPEG_FF, JPEG_SOI, JPEG_FF, 8'hE1, 8'hFF, 8'hFF};
    add_noise(PREFIX_LEN);
    send_image(1'b1);

    // Rule change in the middle of an image: TGA takes over at byte two.
    img = '{JPEG_FF, JPEG_SOI};
    send_image(1'b0);
    set_format(FMT_TGA);
    put_tga(16'd300, 16'd200, 8'd24);
    void'(img.pop_front());
    void'(img.pop_front());
    send_image(1'b1);

    // TGA depth boundaries and a zero width.
    put_tga(16'hFFFF, 16'hFFFF, 8'hFF);
    send_image(1'b1);
    put_tga(16'd0, 16'd7, 8'd16);
    send_image(1'b1);
    put_tga(16'd9, 16'd9, 8'd31);
    send_image(1'b1);

    // BMP depth boundaries and a broken second signature byte.
    set_format(FMT_BMP);
    put_bmp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd32);
    send_image(1'b1);
    put_bmp(32'd640, 32'd480, 16'd24);
    send_image(1'b1);
    put_bmp(32'd1, 32'd1, 16'hFFFF);
    send_image(1'b1);
    put_bmp(32'd5, 32'd5, 16'd0);
    send_image(1'b1);
    img = '{BMP_SIG0, 8'h58, 8'h00};
    send_image(1'b1);

    // Random images: every rule under each idling pattern.
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 60 : 0;
      dst_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 27 : 0;
      for (int k = 0; k < 4; k++) begin
        cur_fmt = fmt_t'(2'((k + mode) % 4));
        set_format(cur_fmt);
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) begin
          random_image(cur_fmt);
          send_image(1'b1);
        end
      end
    end

    settle_block();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("image_header_dimension_sniffer verification clean");
    end else begin
      $display("image_header_dimension_sniffer verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("image_header_dimension_sniffer verification failed");
    $finish;
  end

endmodule
